// ===== src/feedback_queue_task_scheduler_unit_assert.svh =====
// Assertion macros for the feedback queue task scheduler.
// Both macros take a label, a condition and a consequence; they use clk_i and rst_ni.
`ifndef FEEDBACK_QUEUE_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define FEEDBACK_QUEUE_TASK_SCHEDULER_UNIT_ASSERT_SVH

// consequence holds in the same cycle
`define FQTS_AST_IMP(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("fqts: same-cycle check failed");

// consequence holds in the next cycle
`define FQTS_AST_NXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("fqts: next-cycle check failed");

`endif

// ===== src/fqts_pkg.sv =====
// ----------------------------------------------------------------------------
// fqts_pkg
// Shared types and codes of the feedback queue task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package fqts_pkg;

  typedef enum logic [2:0] {
    EV_FINISHED  = 3'd0,
    EV_SUSPENDED = 3'd1,
    EV_RUNNING   = 3'd2,
    EV_STARTED   = 3'd3,
    EV_KILLED    = 3'd4
  } ev_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN,
    ST_SC_QRD,
    ST_SC_TRD,
    ST_SC_CHK,
    ST_START,
    ST_ST_RD,
    ST_ST_EV,
    ST_KL_RD,
    ST_KL_TRD,
    ST_KL_EV,
    ST_FLUSH
  } state_e;

  localparam int unsigned ACT_ARRIVE = 0;
  localparam int unsigned TIMEOUT_RST = 20;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic [15:0] tick;
    logic [7:0]  rem;
    logic [1:0]  level;
    logic [3:0]  id;
    ev_e         ev;
  } evt_t;

endpackage

`default_nettype wire

// ===== src/feedback_queue_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// feedback_queue_task_scheduler_unit
// Four-level feedback queue scheduler with a waiting timeout.
// ----------------------------------------------------------------------------
// Input items on s_axis: tuser = action (0 arrival, 1 tick); tdata holds the
// arrival's priority and burst. Arrivals give no result.
// A tick gives zero or more result items on m_axis (event, id, level,
// remaining work, tick time), tlast on the last one of the tick.
// A tick is worked through in a sequencer around the task memory and the
// queue-slot memory (both with registered reads): it updates the running
// task, scans every queue for timed-out tasks, starts a task if none runs,
// reports each killed task, ends the kill list and flushes the last event.
// A new item is taken only when the previous tick has been worked off.
// Events pass a one-entry holding register (so tlast can be placed) and an
// output register; a stalled receiver stops the sequencer at the next event.
// Reset empties all queues, clears the tick counter and the id counter and
// sets the timeout to 20; the memories need no clearing.
// cfg_we_i writes the timeout register; the user must write it only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module feedback_queue_task_scheduler_unit #(
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned LEVELS     = 4,
  parameter int unsigned TIME_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [7:0]                     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] arrive_priority, [9:2] arrive_burst
  input  wire logic [fqts_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] action
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [2:0] event_res, [6:3] task_id, [8:7] level, [16:9] remaining,
  // [32:17] tick_time
  output logic [fqts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);
  import fqts_pkg::*;

  localparam int unsigned ID_W  = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned SW    = CNT_W + 1;
  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned QA_W  = $clog2(LEVELS * MAX_TASKS);
  localparam int unsigned TW    = TIME_WIDTH;

  function automatic logic [QA_W-1:0] qaddr(input logic [LVL_W-1:0] l,
                                            input logic [ID_W-1:0] p);
    return QA_W'(32'(l) * MAX_TASKS + 32'(p));
  endfunction

  // circular slot position: (h + o) mod MAX_TASKS, both below MAX_TASKS
  function automatic logic [ID_W-1:0] wrap(input logic [ID_W-1:0] h,
                                           input logic [CNT_W-1:0] o);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(o);
    if (s >= SW'(MAX_TASKS)) s = s - SW'(MAX_TASKS);
    return ID_W'(s);
  endfunction

  // memories
  logic [LVL_W-1:0] tl_mem [MAX_TASKS];
  logic [7:0]       tr_mem [MAX_TASKS];
  logic [TW-1:0]    ts_mem [MAX_TASKS];
  logic [ID_W-1:0]  q_mem  [LEVELS*MAX_TASKS];
  logic [ID_W-1:0]  k_mem  [MAX_TASKS];

  logic             t_we, t_re;
  logic [ID_W-1:0]  t_waddr, t_raddr;
  logic [LVL_W-1:0] t_wlvl, t_rd_lvl;
  logic [7:0]       t_wrem, t_rd_rem;
  logic [TW-1:0]    t_wsince, t_rd_since;
  logic             q_we, q_re;
  logic [QA_W-1:0]  q_waddr, q_raddr;
  logic [ID_W-1:0]  q_wdata, q_rd;
  logic             k_we, k_re;
  logic [ID_W-1:0]  k_waddr, k_raddr, k_wdata, k_rd;

  // registers
  state_e           state_q, state_d;
  logic [7:0]       timeout_q;
  logic [TW-1:0]    now_q, now_d;
  logic [CNT_W-1:0] next_id_q, next_id_d;
  logic [ID_W-1:0]  run_id_q, run_id_d;
  logic             run_v_q, run_v_d;
  logic [CNT_W-1:0] len_q [LEVELS];
  logic [CNT_W-1:0] len_d [LEVELS];
  logic [ID_W-1:0]  head_q [LEVELS];
  logic [ID_W-1:0]  head_d [LEVELS];
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [CNT_W-1:0] j_q, j_d, keep_q, keep_d, nk_q, nk_d, kidx_q, kidx_d;
  logic [ID_W-1:0]  cur_id_q, cur_id_d;
  evt_t             pend_q, pend_d, m_data_q, m_data_d;
  logic             pend_v_q, pend_v_d, m_valid_q, m_valid_d, m_last_q, m_last_d;

  // datapath terms
  logic             emit_ok, can_push, push_ev, flush_ev;
  evt_t             ev_new;
  logic [1:0]       in_pr;
  logic [LVL_W-1:0] arr_lvl, lvl_dem, start_lvl;
  logic             start_found, timed;
  logic [7:0]       rem_dec;

  assign in_pr    = s_axis_tdata[1:0];
  assign arr_lvl  = (32'(in_pr) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(in_pr);
  assign rem_dec  = t_rd_rem - 8'd1;
  assign lvl_dem  = (t_rd_lvl < LVL_W'(LEVELS - 1)) ? t_rd_lvl + LVL_W'(1) : t_rd_lvl;
  assign timed    = (now_q - t_rd_since) >= TW'(timeout_q);
  assign emit_ok  = !m_valid_q || m_axis_tready;
  assign can_push = !pend_v_q || emit_ok;

  always_comb begin
    start_found = 1'b0;
    start_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (len_q[i] != '0) begin
        start_found = 1'b1;
        start_lvl   = LVL_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && (32'(s_axis_tuser) != ACT_ARRIVE)) begin
          state_d = run_v_q ? ST_RUN : ST_SC_QRD;
        end
      end
      ST_RUN:    if (can_push) state_d = ST_SC_QRD;
      ST_SC_QRD: begin
        if (j_q < len_q[lvl_q]) begin
          state_d = ST_SC_TRD;
        end else if (32'(lvl_q) == LEVELS - 1) begin
          state_d = ST_START;
        end
      end
      ST_SC_TRD: state_d = ST_SC_CHK;
      ST_SC_CHK: state_d = ST_SC_QRD;
      ST_START:  state_d = (!run_v_q && start_found) ? ST_ST_RD : ST_KL_RD;
      ST_ST_RD:  state_d = ST_ST_EV;
      ST_ST_EV:  if (can_push) state_d = ST_KL_RD;
      ST_KL_RD:  state_d = (kidx_q < nk_q) ? ST_KL_TRD : ST_FLUSH;
      ST_KL_TRD: state_d = ST_KL_EV;
      ST_KL_EV:  if (can_push) state_d = ST_KL_RD;
      ST_FLUSH:  if (!pend_v_q || emit_ok) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control and datapath
  always_comb begin
    t_we = 1'b0; t_re = 1'b0; t_waddr = run_id_q; t_raddr = run_id_q;
    t_wlvl = t_rd_lvl; t_wrem = t_rd_rem; t_wsince = t_rd_since;
    q_we = 1'b0; q_re = 1'b0; q_waddr = '0; q_raddr = '0; q_wdata = cur_id_q;
    k_we = 1'b0; k_re = 1'b0; k_waddr = ID_W'(nk_q); k_raddr = ID_W'(kidx_q);
    k_wdata = cur_id_q;
    now_d = now_q; next_id_d = next_id_q; run_id_d = run_id_q; run_v_d = run_v_q;
    len_d = len_q; head_d = head_q;
    lvl_d = lvl_q; j_d = j_q; keep_d = keep_q; nk_d = nk_q; kidx_d = kidx_q;
    cur_id_d = cur_id_q;
    push_ev = 1'b0; flush_ev = 1'b0;
    ev_new = '{tick: 16'(now_q), rem: t_rd_rem, level: 2'(t_rd_lvl),
               id: 4'(cur_id_q), ev: EV_RUNNING};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (32'(s_axis_tuser) == ACT_ARRIVE) begin
            if (next_id_q < CNT_W'(MAX_TASKS)) begin
              t_we     = 1'b1;
              t_waddr  = ID_W'(next_id_q);
              t_wlvl   = arr_lvl;
              t_wrem   = s_axis_tdata[9:2];
              t_wsince = now_q;
              if (len_q[arr_lvl] < CNT_W'(MAX_TASKS)) begin
                q_we    = 1'b1;
                q_waddr = qaddr(arr_lvl, wrap(head_q[arr_lvl], len_q[arr_lvl]));
                q_wdata = ID_W'(next_id_q);
                len_d[arr_lvl] = len_q[arr_lvl] + CNT_W'(1);
              end
              next_id_d = next_id_q + CNT_W'(1);
            end
          end else begin
            t_re   = run_v_q;
            lvl_d  = '0;
            j_d    = '0;
            keep_d = '0;
            nk_d   = '0;
          end
        end
      end

      ST_RUN: begin
        if (can_push) begin
          t_we   = 1'b1;
          t_wrem = rem_dec;
          ev_new.id  = 4'(run_id_q);
          ev_new.rem = rem_dec;
          if (rem_dec == 8'd0) begin
            ev_new.ev = EV_FINISHED;
            push_ev   = 1'b1;
            run_v_d   = 1'b0;
          end else if (t_rd_lvl != '0) begin
            // demote, restamp and requeue
            t_wlvl       = lvl_dem;
            t_wsince     = now_q;
            ev_new.level = 2'(lvl_dem);
            ev_new.ev    = EV_SUSPENDED;
            push_ev      = 1'b1;
            run_v_d      = 1'b0;
            if (len_q[lvl_dem] < CNT_W'(MAX_TASKS)) begin
              q_we    = 1'b1;
              q_waddr = qaddr(lvl_dem, wrap(head_q[lvl_dem], len_q[lvl_dem]));
              q_wdata = run_id_q;
              len_d[lvl_dem] = len_q[lvl_dem] + CNT_W'(1);
            end
          end else if (timed) begin
            // back to queue 0; the scan reports it as killed
            run_v_d = 1'b0;
            if (len_q[0] < CNT_W'(MAX_TASKS)) begin
              q_we    = 1'b1;
              q_waddr = qaddr('0, wrap(head_q[0], len_q[0]));
              q_wdata = run_id_q;
              len_d[0] = len_q[0] + CNT_W'(1);
            end
          end else begin
            ev_new.ev = EV_RUNNING;
            push_ev   = 1'b1;
          end
        end
      end

      ST_SC_QRD: begin
        if (j_q < len_q[lvl_q]) begin
          q_re    = 1'b1;
          q_raddr = qaddr(lvl_q, wrap(head_q[lvl_q], j_q));
        end else begin
          len_d[lvl_q] = keep_q;
          if (32'(lvl_q) != LEVELS - 1) begin
            lvl_d  = lvl_q + LVL_W'(1);
            j_d    = '0;
            keep_d = '0;
          end
        end
      end

      ST_SC_TRD: begin
        t_re     = 1'b1;
        t_raddr  = q_rd;
        cur_id_d = q_rd;
      end

      ST_SC_CHK: begin
        // survivors are packed down behind the read position
        if (timed) begin
          k_we = 1'b1;
          nk_d = nk_q + CNT_W'(1);
        end else begin
          q_we    = 1'b1;
          q_waddr = qaddr(lvl_q, wrap(head_q[lvl_q], keep_q));
          keep_d  = keep_q + CNT_W'(1);
        end
        j_d = j_q + CNT_W'(1);
      end

      ST_START: begin
        kidx_d = '0;
        if (!run_v_q && start_found) begin
          q_re    = 1'b1;
          q_raddr = qaddr(start_lvl, head_q[start_lvl]);
          head_d[start_lvl] = wrap(head_q[start_lvl], CNT_W'(1));
          len_d[start_lvl]  = len_q[start_lvl] - CNT_W'(1);
        end
      end

      ST_ST_RD: begin
        run_id_d = q_rd;
        run_v_d  = 1'b1;
        t_re     = 1'b1;
        t_raddr  = q_rd;
        cur_id_d = q_rd;
      end

      ST_ST_EV: begin
        if (can_push) begin
          t_we      = 1'b1;
          t_waddr   = cur_id_q;
          t_wsince  = now_q;
          ev_new.ev = EV_STARTED;
          push_ev   = 1'b1;
        end
      end

      ST_KL_RD: begin
        k_re = kidx_q < nk_q;
      end

      ST_KL_TRD: begin
        t_re     = 1'b1;
        t_raddr  = k_rd;
        cur_id_d = k_rd;
      end

      ST_KL_EV: begin
        if (can_push) begin
          ev_new.ev = EV_KILLED;
          push_ev   = 1'b1;
          kidx_d    = kidx_q + CNT_W'(1);
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q || emit_ok) begin
          flush_ev = pend_v_q;
          now_d    = now_q + TW'(1);
        end
      end

      default: ;
    endcase
  end

  // holding register and output register
  always_comb begin
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (push_ev) begin
      if (pend_v_q) begin
        m_valid_d = 1'b1;
        m_data_d  = pend_q;
        m_last_d  = 1'b0;
      end
      pend_d   = ev_new;
      pend_v_d = 1'b1;
    end else if (flush_ev) begin
      m_valid_d = 1'b1;
      m_data_d  = pend_q;
      m_last_d  = 1'b1;
      pend_v_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tl_mem[t_waddr] <= t_wlvl;
      tr_mem[t_waddr] <= t_wrem;
      ts_mem[t_waddr] <= t_wsince;
    end
    if (t_re) begin
      t_rd_lvl   <= tl_mem[t_raddr];
      t_rd_rem   <= tr_mem[t_raddr];
      t_rd_since <= ts_mem[t_raddr];
    end
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd <= q_mem[q_raddr];
    if (k_we) k_mem[k_waddr] <= k_wdata;
    if (k_re) k_rd <= k_mem[k_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      timeout_q <= 8'(TIMEOUT_RST);
      now_q     <= '0;
      next_id_q <= '0;
      run_id_q  <= '0;
      run_v_q   <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        len_q[i]  <= '0;
        head_q[i] <= '0;
      end
      lvl_q     <= '0;
      j_q       <= '0;
      keep_q    <= '0;
      nk_q      <= '0;
      kidx_q    <= '0;
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      now_q     <= now_d;
      next_id_q <= next_id_d;
      run_id_q  <= run_id_d;
      run_v_q   <= run_v_d;
      len_q     <= len_d;
      head_q    <= head_d;
      lvl_q     <= lvl_d;
      j_q       <= j_d;
      keep_q    <= keep_d;
      nk_q      <= nk_d;
      kidx_q    <= kidx_d;
      pend_v_q  <= pend_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_id_q <= cur_id_d;
    pend_q   <= pend_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = OUT_DATA_W'({m_data_q.tick, m_data_q.rem, m_data_q.level,
                                      m_data_q.id, m_data_q.ev});

  `include "feedback_queue_task_scheduler_unit_assert.svh"

  `FQTS_AST_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q)
  `FQTS_AST_IMP(a_kill_bound, 1'b1, nk_q <= CNT_W'(MAX_TASKS))
  `FQTS_AST_IMP(a_id_bound, 1'b1, next_id_q <= CNT_W'(MAX_TASKS))
  `FQTS_AST_NXT(a_tick_step, state_q == ST_FLUSH && state_d == ST_IDLE,
                now_q == $past(now_q) + TW'(1))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives arrivals and ticks into the feedback queue scheduler. A behavioural
// scheduler in the bench predicts the event items of each tick, and every
// item leaving the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import fqts_pkg::*;

  localparam int unsigned ACT_TICK   = 1;
  localparam int unsigned N_TASKS    = 16;
  localparam int unsigned N_LEVELS   = 4;
  localparam int unsigned SETTLE_CYC = 120;
  localparam int unsigned CYC_LIMIT  = 1000000;

  typedef struct {
    evt_t e;
    bit   last;
  } sched_evt_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [7:0]            cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  feedback_queue_task_scheduler_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // scheduler state mirrored in the bench
  bit [7:0]   timeout_val;
  bit [1:0]   task_lvl [N_TASKS];
  bit [7:0]   task_work[N_TASKS];
  bit [15:0]  task_stamp[N_TASKS];
  int         ready_q[N_LEVELS][$];
  int         cur_id;
  bit         cur_valid;
  bit [15:0]  tick_now;
  int         ids_used;

  sched_evt_t evt_q[$];
  int         errors;
  bit         tx_idle_en;
  bit         rx_idle_en;
  int         rx_hold;
  int         cyc;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_evt(ev_e ev, int id);
    sched_evt_t s;
    s.e.ev    = ev;
    s.e.id    = id[3:0];
    s.e.level = task_lvl[id];
    s.e.rem   = task_work[id];
    s.e.tick  = tick_now;
    s.last    = 1'b0;
    evt_q.push_back(s);
  endfunction

  function automatic bit timed_out(int id);
    bit [15:0] waited;
    waited = tick_now - task_stamp[id];
    return waited >= 16'(timeout_val);
  endfunction

  function automatic void sched_arrive(bit [1:0] prio, bit [7:0] work);
    if (ids_used >= N_TASKS) return;  // capacity used up: ignored
    task_lvl[ids_used]   = prio;
    task_work[ids_used]  = work;
    task_stamp[ids_used] = tick_now;
    ready_q[prio].push_back(ids_used);
    ids_used++;
  endfunction

  function automatic void sched_tick();
    int first;
    int killed[$];
    int kept[$];
    int id;
    first = evt_q.size();
    if (cur_valid) begin
      id = cur_id;
      task_work[id] = task_work[id] - 8'd1;
      if (task_work[id] == 0) begin
        push_evt(EV_FINISHED, id);
        cur_valid = 1'b0;
      end else if (task_lvl[id] != 0) begin
        if (task_lvl[id] < N_LEVELS - 1) task_lvl[id]++;
        ready_q[task_lvl[id]].push_back(id);
        task_stamp[id] = tick_now;
        push_evt(EV_SUSPENDED, id);
        cur_valid = 1'b0;
      end else if (timed_out(id)) begin
        // back to queue 0 unstamped, so the scan below kills it
        ready_q[0].push_back(id);
        cur_valid = 1'b0;
      end else begin
        push_evt(EV_RUNNING, id);
      end
    end
    for (int lv = 0; lv < N_LEVELS; lv++) begin
      kept.delete();
      foreach (ready_q[lv][j]) begin
        if (timed_out(ready_q[lv][j])) killed.push_back(ready_q[lv][j]);
        else kept.push_back(ready_q[lv][j]);
      end
      ready_q[lv] = kept;
    end
    if (!cur_valid) begin
      for (int lv = 0; lv < N_LEVELS; lv++) begin
        if (ready_q[lv].size() > 0) begin
          id = ready_q[lv].pop_front();
          cur_id = id;
          cur_valid = 1'b1;
          task_stamp[id] = tick_now;
          push_evt(EV_STARTED, id);
          break;
        end
      end
    end
    foreach (killed[k]) push_evt(EV_KILLED, killed[k]);
    if (evt_q.size() > first) evt_q[evt_q.size()-1].last = 1'b1;
    tick_now = tick_now + 16'd1;
  endfunction

  // one item on the input stream; valid stays high into the next call
  task automatic send_item(bit act, bit [1:0] prio, bit [7:0] work);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, work, prio};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_ARRIVE[0]) sched_arrive(prio, work);
    else sched_tick();
  endtask

  task automatic tick_n(int n);
    repeat (n) send_item(ACT_TICK[0], 2'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (evt_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_timeout(bit [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_val = v;
  endtask

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    sched_evt_t x;
    evt_t       got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = evt_t'(m_axis_tdata[$bits(evt_t)-1:0]);
        if (evt_q.size() == 0) begin
          $error("unexpected item: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          x = evt_q.pop_front();
          if (got.ev !== x.e.ev) begin
            $error("event_res: exp %0d got %0d", x.e.ev, got.ev); errors++;
          end
          if (got.id !== x.e.id) begin
            $error("task_id: exp %0d got %0d", x.e.id, got.id); errors++;
          end
          if (got.level !== x.e.level) begin
            $error("level: exp %0d got %0d", x.e.level, got.level); errors++;
          end
          if (got.rem !== x.e.rem) begin
            $error("remaining: exp %0d got %0d", x.e.rem, got.rem); errors++;
          end
          if (got.tick !== x.e.tick) begin
            $error("tick_time: exp %0d got %0d", x.e.tick, got.tick); errors++;
          end
          if (m_axis_tlast !== x.last) begin
            $error("last_of_run: exp %0d got %0d", x.last, m_axis_tlast); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_quiet_ticks();
    tick_n(4);  // nothing queued: no items expected
    wait_idle();
  endtask

  task automatic test_directed_mix();
    send_item(ACT_ARRIVE[0], 2'd0, 8'd3);
    send_item(ACT_ARRIVE[0], 2'd3, 8'd255);
    send_item(ACT_ARRIVE[0], 2'd1, 8'd0);   // work 0; it stays queued through these ticks
    send_item(ACT_ARRIVE[0], 2'd2, 8'd1);
    send_item(ACT_ARRIVE[0], 2'd0, 8'd170);
    tick_n(18);
    wait_idle();
  endtask

  task automatic test_zero_timeout();
    set_timeout(8'd0);
    send_item(ACT_ARRIVE[0], 2'd2, 8'd5);
    send_item(ACT_ARRIVE[0], 2'd0, 8'd9);
    send_item(ACT_ARRIVE[0], 2'd1, 8'd85);
    tick_n(3);
    wait_idle();
  endtask

  task automatic test_level0_timeout();
    set_timeout(8'd1);
    send_item(ACT_ARRIVE[0], 2'd0, 8'd200);
    tick_n(4);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_timeout(8'd255);
    send_item(ACT_ARRIVE[0], 2'd3, 8'd100);
    send_item(ACT_ARRIVE[0], 2'd2, 8'd60);
    rx_hold = 400;
    tick_n(40);
    wait_idle();
  endtask

  // once the ids run out, later arrivals are ignored
  task automatic test_random(int n_ticks, bit [7:0] tmo);
    int done;
    set_timeout(tmo);
    done = 0;
    while (done < n_ticks) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(ACT_ARRIVE[0], 2'($urandom), 8'($urandom_range(1, 40)));
      end else begin
        send_item(ACT_TICK[0], 2'($urandom), 8'($urandom));
        done++;
      end
      if (done == n_ticks / 2 && $urandom_range(0, 1) == 0) begin
        s_axis_tvalid <= 1'b0;
        while (evt_q.size() > 0) @(posedge clk_i);
      end
    end
    wait_idle();
  endtask

  initial begin
    errors        = 0;
    cyc           = 0;
    rx_hold       = 0;
    rx_idle_en    = 1'b1;
    tx_idle_en    = 1'b1;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    timeout_val   = 8'(TIMEOUT_RST);
    cur_id        = 0;
    cur_valid     = 1'b0;
    tick_now      = 16'd0;
    ids_used      = 0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quiet_ticks();
    test_directed_mix();
    test_zero_timeout();
    test_level0_timeout();
    test_backpressure();
    test_random(60, 8'd20);
    test_random(60, 8'($urandom_range(2, 254)));
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(50, 8'd255);

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/fqts_pkg.sv
src/feedback_queue_task_scheduler_unit.sv
tb/testbench.sv
